@@ hw/rtl/urcp_pkg.sv @@
// package for the unique random cell picker
// widths, status and command codes, register indexes and the divider beat types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package urcp_pkg;

  localparam int unsigned MAX_CELLS = 4096;
  localparam int unsigned CELL_W    = $clog2(MAX_CELLS);
  localparam int unsigned CNT_W     = $clog2(MAX_CELLS) + 1;
  localparam int unsigned REG_W     = 13;
  localparam int unsigned PROD_W    = 2 * REG_W;
  localparam int unsigned WORD_W    = 31;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned STEP_W    = $clog2(WORD_W + 1);
  localparam int unsigned DIV_W     = (CNT_W > REG_W) ? CNT_W : REG_W;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [IDX_W-1:0] REG_ROWS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COLS = IDX_W'(1);

  localparam logic CMD_PICK  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_PICKED    = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_CLEARED   = 2'd2
  } status_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [WORD_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [DIV_W-1:0]  remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/urcp_divider.sv @@
// shared restoring divider, one quotient bit per cycle, msb first
// the dividend is given aligned to the top and only the requested number of bits are worked
// depends on urcp_pkg
`timescale 1ns / 1ps
`default_nettype none

module urcp_divider (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire urcp_pkg::div_req_t req_i,
  output urcp_pkg::div_rsp_t      rsp_o
);
  import urcp_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] left_q;
  logic [WORD_W-1:0] quo_q;
  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W-1:0]  div_q;

  logic [DIV_W:0]    trial;
  logic              ge;
  logic [DIV_W:0]    diff;

  assign trial = {rem_q, quo_q[WORD_W-1]};
  assign ge    = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      left_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        left_q <= req_i.steps;
      end else if (busy_q) begin
        left_q <= left_q - STEP_W'(1);
        if (left_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[WORD_W-2:0], ge};
      rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

@@ hw/rtl/unique_random_cell_picker.sv @@
// unique random cell picker: draws grid cells at random without repeats
// sequencer, remap memory with valid bit per entry and clearing sweep
// depends on urcp_pkg and urcp_divider
//
// usage: set grid_rows (index 0) and grid_cols (index 1) on the cfg channel while idle;
// each write to either starts a new grid. input beats carry cmd in tuser and random_word in tdata.
// a pick returns row and column of a cell not picked since the last clear, or status
// exhausted when none are left; a clear returns status cleared.
// one input beat gives one output beat. a pick runs through the divider for random_word
// mod count, the remap memory read/read/write, the divider again for the split by
// grid_cols and then the result and output registers; the next input beat is taken once
// its result has moved to the output register. the divider is shared by both divisions.
// an exhausted answer goes from the result register to the output register with no divider step.
// a clear, a register write and reset each run a sweep over all 4096 entries of the remap
// memory, one entry a cycle, during which no input beat is accepted; a clear answers
// once the sweep has ended. cfg writes are always taken.
// a finished result waits in the output register while the receiver stalls; the next
// input beat is taken meanwhile but its result waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module unique_random_cell_picker (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // config write channel
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [urcp_pkg::IDX_W-1:0]        cfg_index_i,
  input  wire  [urcp_pkg::REG_W-1:0]        cfg_data_i,
  // input beats
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [urcp_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // random_word[30:0], zero
  input  wire                               s_axis_tuser,   // cmd
  // output beats
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [urcp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // row_index[11:0], col_index[23:12]
  output logic [urcp_pkg::STAT_W-1:0]       m_axis_tuser    // status
);
  import urcp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD_WAIT,
    S_RD_POS,
    S_RD_LAST,
    S_DIV_WAIT,
    S_CLR_WAIT,
    S_RESP
  } state_e;

  state_e            state_q;
  logic [REG_W-1:0]  rows_q;
  logic [REG_W-1:0]  cols_q;
  logic [CNT_W-1:0]  cells_q;
  logic [CNT_W-1:0]  count_q;
  logic              sweep_q;
  logic [CELL_W-1:0] sweep_addr_q;
  logic [CELL_W-1:0] pos_q;
  logic [CELL_W-1:0] picked_q;
  logic [ROW_W-1:0]  res_row_q;
  logic [COL_W-1:0]  res_col_q;
  status_e           res_stat_q;
  logic              m_valid_q;
  logic [ROW_W-1:0]  m_row_q;
  logic [COL_W-1:0]  m_col_q;
  status_e           m_stat_q;

  // remap memory: valid bit on top of the cell index
  logic [CELL_W:0]   mem [MAX_CELLS];
  logic [CELL_W:0]   rd_q;
  logic [CELL_W-1:0] raddr;
  logic              we;
  logic [CELL_W-1:0] waddr;
  logic [CELL_W:0]   wdata;

  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  cells_d;
  logic [CNT_W-1:0]  last;
  logic [CELL_W-1:0] rd_cell;
  logic              cfg_hit;
  logic              in_acc;
  logic              out_free;
  logic              resp_load;
  logic              sweep_start;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  urcp_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign prod    = PROD_W'(rows_q) * PROD_W'(cols_q);
  assign cells_d = (prod > PROD_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : prod[CNT_W-1:0];
  assign last    = count_q - CNT_W'(1);

  assign cfg_ready_o   = 1'b1;
  assign cfg_hit       = cfg_valid_i && ((cfg_index_i == REG_ROWS) || (cfg_index_i == REG_COLS));
  assign s_axis_tready = (state_q == S_IDLE) && !sweep_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign resp_load     = (state_q == S_RESP) && out_free;
  assign sweep_start   = cfg_hit || (in_acc && (s_axis_tuser == CMD_CLEAR));

  always_comb begin
    case (state_q)
      S_MOD_WAIT: raddr = div_rsp.remainder[CELL_W-1:0];
      S_RD_POS:   raddr = last[CELL_W-1:0];
      default:    raddr = pos_q;
    endcase
  end

  // cell at the address just read: remapped if marked, else the address itself
  always_comb begin
    if (state_q == S_RD_POS) begin
      rd_cell = rd_q[CELL_W] ? rd_q[CELL_W-1:0] : pos_q;
    end else begin
      rd_cell = rd_q[CELL_W] ? rd_q[CELL_W-1:0] : last[CELL_W-1:0];
    end
  end

  always_comb begin
    if (sweep_q) begin
      we    = 1'b1;
      waddr = sweep_addr_q;
      wdata = '0;
    end else begin
      we    = (state_q == S_RD_LAST);
      waddr = pos_q;
      wdata = {1'b1, rd_cell};
    end
  end

  always_comb begin
    div_req = '0;
    if (in_acc && (s_axis_tuser == CMD_PICK) && (count_q != '0)) begin
      div_req.start    = 1'b1;
      div_req.steps    = STEP_W'(WORD_W);
      div_req.dividend = s_axis_tdata[WORD_W-1:0];
      div_req.divisor  = DIV_W'(count_q);
    end else if (state_q == S_RD_LAST) begin
      div_req.start    = 1'b1;
      div_req.steps    = STEP_W'(CELL_W);
      div_req.dividend = WORD_W'(picked_q) << (WORD_W - CELL_W);
      div_req.divisor  = DIV_W'(cols_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rows_q       <= REG_W'(1);
      cols_q       <= REG_W'(1);
      cells_q      <= CNT_W'(1);
      count_q      <= CNT_W'(1);
      sweep_q      <= 1'b1;
      sweep_addr_q <= '0;
      pos_q        <= '0;
      picked_q     <= '0;
      res_row_q    <= '0;
      res_col_q    <= '0;
      res_stat_q   <= ST_PICKED;
      m_valid_q    <= 1'b0;
      m_row_q      <= '0;
      m_col_q      <= '0;
      m_stat_q     <= ST_PICKED;
    end else begin
      cells_q <= cells_d;

      if (resp_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      // clearing sweep, count restored at its end
      if (sweep_start) begin
        sweep_q      <= 1'b1;
        sweep_addr_q <= '0;
      end else if (sweep_q) begin
        sweep_addr_q <= sweep_addr_q + CELL_W'(1);
        if (sweep_addr_q == CELL_W'(MAX_CELLS - 1)) begin
          sweep_q <= 1'b0;
          count_q <= cells_q;
        end
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_row_q <= '0;
            res_col_q <= '0;
            if (s_axis_tuser == CMD_CLEAR) begin
              res_stat_q <= ST_CLEARED;
              state_q    <= S_CLR_WAIT;
            end else if (count_q == '0) begin
              res_stat_q <= ST_EXHAUSTED;
              state_q    <= S_RESP;
            end else begin
              res_stat_q <= ST_PICKED;
              state_q    <= S_MOD_WAIT;
            end
          end
        end
        S_MOD_WAIT: begin
          if (div_rsp.done) begin
            pos_q   <= div_rsp.remainder[CELL_W-1:0];
            state_q <= S_RD_POS;
          end
        end
        S_RD_POS: begin
          picked_q <= rd_cell;
          state_q  <= S_RD_LAST;
        end
        S_RD_LAST: begin
          count_q <= last;
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (cols_q != '0) begin
              res_row_q <= div_rsp.quotient[ROW_W-1:0];
              res_col_q <= div_rsp.remainder[COL_W-1:0];
            end
            state_q <= S_RESP;
          end
        end
        S_CLR_WAIT: begin
          if (!sweep_q) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            m_row_q  <= res_row_q;
            m_col_q  <= res_col_q;
            m_stat_q <= res_stat_q;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // a register write starts a new grid
      if (cfg_hit) begin
        if (cfg_index_i == REG_ROWS) begin
          rows_q <= cfg_data_i;
        end else begin
          cols_q <= cfg_data_i;
        end
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_col_q, m_row_q};
  assign m_axis_tuser  = m_stat_q;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// self-checking bench for unique_random_cell_picker: a directed table, then random grids
// answers are predicted by a local swap-remove model of the grid and its remap marks,
// but check rows give answers from the table; depends on urcp_pkg and the picker rtl
`timescale 1ns / 1ps

module tb;
  import urcp_pkg::*;

  localparam int unsigned ITEMS_TOTAL = 1950;
  localparam int unsigned PICK_CAP    = 60;
  localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_TOP   = {IDX_W{1'b1}};

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    status_e          st;
  } answer_t;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [IDX_W-1:0]  idx;
    logic [REG_W-1:0]  val;
    logic              cmd;
    logic [WORD_W-1:0] word;
    logic              typed;
    answer_t           ans;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [IDX_W-1:0]      cfg_index_i;
  logic [REG_W-1:0]      cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // random_word[30:0], zero
  logic                  s_axis_tuser;   // cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // row_index[11:0], col_index[23:12]
  logic [STAT_W-1:0]     m_axis_tuser;   // status

  unique_random_cell_picker DUT (.*);

  // grid model
  logic [REG_W-1:0] rows_set;
  logic [REG_W-1:0] cols_set;
  logic [CELL_W-1:0] remap_cell [MAX_CELLS];
  bit               remap_set  [MAX_CELLS];
  logic [CNT_W-1:0] cells_left;

  answer_t     answers_due [$];
  answer_t     head;
  plan_row_t   plan [34];
  int unsigned items_sent = 0;
  int unsigned err_cnt = 0;
  int unsigned send_idle = 26;
  int unsigned recv_idle = 81;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [CNT_W-1:0] grid_cells();
    int unsigned prod;
    prod = 32'(rows_set) * 32'(cols_set);
    return (prod > MAX_CELLS) ? CNT_W'(MAX_CELLS) : CNT_W'(prod);
  endfunction

  function automatic void restart_grid();
    foreach (remap_set[i]) remap_set[i] = 1'b0;
    cells_left = grid_cells();
  endfunction

  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    if (idx == REG_ROWS) begin
      rows_set = val;
    end else if (idx == REG_COLS) begin
      cols_set = val;
    end else begin
      return;
    end
    restart_grid();
  endfunction

  function automatic int unsigned cell_at(int unsigned pos);
    return remap_set[pos] ? 32'(remap_cell[pos]) : pos;
  endfunction

  function automatic answer_t shuffle_step(logic cmd, logic [WORD_W-1:0] word);
    answer_t     a;
    int unsigned pos;
    int unsigned last;
    int unsigned picked;
    a = '0;
    a.st = ST_PICKED;
    if (cmd == CMD_CLEAR) begin
      restart_grid();
      a.st = ST_CLEARED;
      return a;
    end
    if (cells_left == 0) begin
      a.st = ST_EXHAUSTED;
      return a;
    end
    pos = 32'(word) % 32'(cells_left);
    last = 32'(cells_left) - 1;
    picked = cell_at(pos);
    remap_cell[pos] = CELL_W'(cell_at(last));
    remap_set[pos] = 1'b1;
    cells_left = CNT_W'(last);
    if (cols_set != 0) begin
      a.row = ROW_W'(picked / 32'(cols_set));
      a.col = COL_W'(picked % 32'(cols_set));
    end
    return a;
  endfunction

  function automatic plan_row_t plan_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic plan_row_t plan_item(logic cmd, logic [WORD_W-1:0] word);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.cmd = cmd;
    r.word = word;
    return r;
  endfunction

  function automatic plan_row_t plan_check(logic cmd, logic [WORD_W-1:0] word,
                                           int unsigned row, int unsigned col, status_e st);
    plan_row_t r;
    r = plan_item(cmd, word);
    r.typed = 1'b1;
    r.ans.row = ROW_W'(row);
    r.ans.col = COL_W'(col);
    r.ans.st = st;
    return r;
  endfunction

  function automatic logic [REG_W-1:0] extreme_size();
    case ($urandom_range(4))
      0: return '0;
      1: return REG_W'(1);
      2: return REG_W'(64);
      3: return REG_W'(MAX_CELLS);
      default: return '1;
    endcase
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 100) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_item(input logic cmd, input logic [WORD_W-1:0] word,
                           input logic typed, input answer_t typed_ans);
    answer_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = cmd;
    s_axis_tdata = IN_DATA_W'(word);
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = shuffle_step(cmd, word);
    answers_due.push_back(typed ? typed_ans : predicted);
    items_sent++;
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
  endtask

  // one random grid: set it up, draw up to 63 times, sometimes clear and draw again
  task automatic run_phase();
    logic [REG_W-1:0] r_val;
    logic [REG_W-1:0] c_val;
    int unsigned      budget;
    int unsigned      roll;
    bit               again;
    if ($urandom_range(99) < 8) begin
      r_val = extreme_size();
      c_val = extreme_size();
    end else begin
      r_val = REG_W'($urandom_range(12, 1));
      c_val = REG_W'($urandom_range(12, 1));
    end
    wait_quiet();
    roll = $urandom_range(9);
    if (roll == 0) begin
      write_reg(REG_ROWS, r_val);
    end else if (roll == 1) begin
      write_reg(REG_COLS, c_val);
    end else if (roll < 6) begin
      write_reg(REG_ROWS, r_val);
      write_reg(REG_COLS, c_val);
    end else begin
      write_reg(REG_COLS, c_val);
      write_reg(REG_ROWS, r_val);
    end
    if ($urandom_range(9) == 0) write_reg(IDX_W'($urandom_range(255, 2)), REG_W'($urandom()));
    again = 1'b1;
    while (again) begin
      budget = ((cells_left > PICK_CAP) ? PICK_CAP : 32'(cells_left)) + $urandom_range(3);
      repeat (budget) begin
        roll = $urandom_range(99);
        if (roll < 3) wait_quiet();
        send_item((roll >= 98) ? CMD_CLEAR : CMD_PICK, WORD_W'($urandom()), 1'b0, '0);
      end
      again = ($urandom_range(2) == 0);
      if (again) send_item(CMD_CLEAR, WORD_W'($urandom()), 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) m_axis_tready = ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        flag_error($sformatf("unexpected beat data %h status %0d", m_axis_tdata, m_axis_tuser));
      end else begin
        head = answers_due.pop_front();
        if (m_axis_tdata[ROW_W-1:0] !== head.row || m_axis_tdata[ROW_W +: COL_W] !== head.col
            || m_axis_tuser !== head.st)
          flag_error($sformatf("row %0d col %0d status %0d, wanted row %0d col %0d status %0d",
                               m_axis_tdata[ROW_W-1:0], m_axis_tdata[ROW_W +: COL_W],
                               m_axis_tuser, head.row, head.col, head.st));
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_PICK;
    rows_set = REG_W'(1);
    cols_set = REG_W'(1);
    restart_grid();
    plan = '{
      plan_check(CMD_PICK,  31'h0,        0,    0,    ST_PICKED),
      plan_check(CMD_PICK,  31'h7FFFFFFF, 0,    0,    ST_EXHAUSTED),
      plan_check(CMD_CLEAR, 31'h0,        0,    0,    ST_CLEARED),
      plan_check(CMD_PICK,  31'h7FFFFFFF, 0,    0,    ST_PICKED),
      plan_reg(REG_ROWS, 13'd0),
      plan_check(CMD_PICK,  31'h0,        0,    0,    ST_EXHAUSTED),
      plan_check(CMD_CLEAR, 31'h7FFFFFFF, 0,    0,    ST_CLEARED),
      plan_check(CMD_PICK,  31'h7FFFFFFF, 0,    0,    ST_EXHAUSTED),
      plan_reg(REG_ROWS, 13'h1FFF),
      plan_reg(REG_COLS, 13'h1FFF),
      plan_check(CMD_PICK,  31'h7FFFFFFF, 0,    4095, ST_PICKED),
      plan_check(CMD_PICK,  31'h0,        0,    0,    ST_PICKED),
      plan_item(CMD_PICK, 31'd4094),
      plan_item(CMD_PICK, 31'h0),
      plan_reg(REG_COLS, 13'd1),
      plan_check(CMD_PICK,  31'h7FFFFFFF, 4095, 0,    ST_PICKED),
      plan_reg(REG_ROWS, 13'd4096),
      plan_reg(REG_COLS, 13'd4096),
      plan_check(CMD_PICK,  31'h7FFFFFFF, 0,    4095, ST_PICKED),
      plan_reg(REG_TOP, 13'd0),
      plan_item(CMD_PICK, 31'h55555555),
      plan_reg(REG_ROWS, 13'd3),
      plan_reg(REG_COLS, 13'd5),
      plan_item(CMD_PICK, 31'd7),
      plan_item(CMD_PICK, 31'h2AAAAAAA),
      plan_item(CMD_PICK, 31'h0),
      plan_item(CMD_PICK, 31'd13),
      plan_item(CMD_PICK, 31'h7FFFFFFF),
      plan_check(CMD_CLEAR, 31'h1234,     0,    0,    ST_CLEARED),
      plan_check(CMD_PICK,  31'd14,       2,    4,    ST_PICKED),
      plan_reg(REG_COLS, 13'd0),
      plan_check(CMD_PICK,  31'd1234,     0,    0,    ST_EXHAUSTED),
      plan_reg(REG_SPARE, 13'h1FFF),
      plan_check(CMD_PICK,  31'h7FFFFFFF, 0,    0,    ST_EXHAUSTED)
    };
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        wait_quiet();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_item(plan[i].cmd, plan[i].word, plan[i].typed, plan[i].ans);
      end
    end
    while (items_sent < ITEMS_TOTAL) begin
      if (items_sent < ITEMS_TOTAL / 3) begin
        send_idle = 26;
        recv_idle = 81;
      end else if (items_sent < 2 * ITEMS_TOTAL / 3) begin
        send_idle = 81;
        recv_idle = 26;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      run_phase();
    end
    wait_quiet();
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && answers_due.size() == 0) begin
      $display("unique_random_cell_picker regression: pass");
    end else begin
      $display("unique_random_cell_picker regression: fail");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("unique_random_cell_picker regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/urcp_pkg.sv
hw/rtl/urcp_divider.sv
hw/rtl/unique_random_cell_picker.sv
dv/tb.sv
